// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// ----- hdl/ttu_pkg.sv -----
// Types and constants shared by the text-to-integer parser modules.
package ttu_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned RadixW  = 6;

  localparam logic [RadixW-1:0] RadixMax = 6'd36;
  localparam logic [RadixW-1:0] RadixOne = 6'd1;
  localparam logic [RadixW-1:0] RadixAuto = 6'd0;
  localparam logic [RadixW-1:0] RadixOct = 6'd8;
  localparam logic [RadixW-1:0] RadixDec = 6'd10;
  localparam logic [RadixW-1:0] RadixHex = 6'd16;
  localparam logic [RadixW-1:0] RadixReset = 6'd10;

  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7a;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLoX   = 8'h78;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] UpBias  = 8'd55;  // 'A' - 10
  localparam logic [7:0] LoBias  = 8'd87;  // 'a' - 10

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_RADIX = 2'd2,
    ST_NODIG = 2'd3
  } status_e;

  typedef struct packed {
    logic              is_space;
    logic              is_minus;
    logic              is_plus;
    logic              is_zero;
    logic              is_x;
    logic              is_digit;
    logic [RadixW-1:0] dval;
  } char_class_t;

  typedef struct packed {
    logic [ValueW-1:0] sum;
    logic              ovf;
  } mac_t;

  typedef struct packed {
    status_e            status;
    logic [OffsetW-1:0] end_offset;
    logic [ValueW-1:0]  value;
  } res_t;

endpackage

// ----- hdl/text_to_unsigned_integer_parser.sv -----
// Top level of the streaming text-to-unsigned-integer parser.
// Converts a byte stream to a 64-bit value with strtoull rules in the C locale.
// Each string opens with a beat whose tuser bit is set; leading white space
// is skipped, one '+' or '-' is taken, and in radix 0 or 16 a 0x / 0X prefix
// is accepted (radix 0 picks 8, 10 or 16 from the prefix). Exactly one result
// beat leaves per string, on the first byte that is not a digit of the radix,
// normally the NUL; an invalid radix (1 or above 36) answers on the start
// byte itself. Bytes outside a string are dropped, and a new start abandons a
// conversion in progress without a result. The radix register is sampled on
// each start beat; write it only while the block is idle. Throughput is one
// byte per cycle unless the result stream stalls: each beat passes through an
// input register, one decode and one 64-by-6 multiply-add with overflow
// check, and a result lands in the result register, which presents it.
// s_axis_tready follows m_axis_tready combinationally when both
// registers are full. No clearing pass is needed after reset.
module text_to_unsigned_integer_parser
  import ttu_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: radix
  input  logic              cfg_we_i,
  input  logic [RadixW-1:0] cfg_wdata_i,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] char_code
  input  logic              s_axis_tuser,   // [0] string_start
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [87:0]       m_axis_tdata    // [63:0] value, [79:64] end_offset,
                                            // [81:80] status, [87:82] zero
);

  logic [RadixW-1:0] radix_q;
  logic              in_vld_q, in_vld_d;
  logic [7:0]        char_q;
  logic              start_q;
  logic              in_acc, step_en, out_vld;
  res_t              res;

  // Radix register, reset to decimal
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // Advance the held beat whenever the result register is free or draining
  assign step_en       = in_vld_q && (!out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step_en;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (step_en) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Hold the input beat payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q  <= s_axis_tdata;
      start_q <= s_axis_tuser;
    end
  end

  ttu_parse #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .char_i      (char_q),
    .start_i     (start_q),
    .radix_i     (radix_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (out_vld),
    .res_o       (res)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {6'b0, res.status, res.end_offset, res.value};

endmodule

// ----- hdl/ttu_decode.sv -----
// Character classifier: white space, sign, prefix letters and digit value.
module ttu_decode
  import ttu_pkg::*;
(
  input  logic [7:0]  char_i,
  output char_class_t cls_o
);

  logic is_num, is_up, is_lo;
  logic [7:0] dval_full;

  assign is_num = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_up  = (char_i >= ChUpA) && (char_i <= ChUpZ);
  assign is_lo  = (char_i >= ChLoA) && (char_i <= ChLoZ);

  always_comb begin
    if (is_num) begin
      dval_full = char_i - ChZero;
    end else if (is_up) begin
      dval_full = char_i - UpBias;
    end else begin
      dval_full = char_i - LoBias;
    end
  end

  assign cls_o.is_space = (char_i == ChSpace) || ((char_i >= ChTab) && (char_i <= ChCr));
  assign cls_o.is_minus = (char_i == ChMinus);
  assign cls_o.is_plus  = (char_i == ChPlus);
  assign cls_o.is_zero  = (char_i == ChZero);
  assign cls_o.is_x     = (char_i == ChLoX) || (char_i == ChUpX);
  assign cls_o.is_digit = is_num || is_up || is_lo;
  assign cls_o.dval     = dval_full[RadixW-1:0];

endmodule

// ----- hdl/ttu_mac.sv -----
// Multiply-add of the accumulator by the radix, with overflow detect.
module ttu_mac
  import ttu_pkg::*;
(
  input  logic [ValueW-1:0] acc_i,
  input  logic [RadixW-1:0] radix_i,
  input  logic [RadixW-1:0] digit_i,
  output mac_t              mac_o
);

  localparam int unsigned ProdW = ValueW + RadixW;

  logic [ProdW-1:0] prod;

  // digit < radix, so the sum exceeds 64 bits exactly when strtoull overflows
  assign prod = ProdW'(acc_i) * ProdW'(radix_i) + ProdW'(digit_i);

  assign mac_o.sum = prod[ValueW-1:0];
  assign mac_o.ovf = |prod[ProdW-1:ValueW];

endmodule

// ----- hdl/ttu_parse.sv -----
// Parse state machine and result register.
`include "assert_macros.svh"

module ttu_parse
  import ttu_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  logic [7:0]        char_i,
  input  logic              start_i,
  input  logic [RadixW-1:0] radix_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output res_t              res_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_SIGNED, PH_ZERO, PH_HEXPFX, PH_DIGITS
  } phase_e;

  typedef enum logic [1:0] {
    DS_NONE, DS_SOME, DS_OVER
  } dstate_e;

  localparam int unsigned ExtW = (OFFSET_BITS > OffsetW) ? OFFSET_BITS : OffsetW;

  phase_e                 phase_q, phase_d, phase_w;
  dstate_e                ds_q, ds_d, ds_w;
  logic                   neg_q, neg_d, neg_w;
  logic [ValueW-1:0]      acc_q, acc_d, acc_w;
  logic [RadixW-1:0]      erad_q, erad_d, erad_w;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_w;
  logic                   px_q, px_d, px_w;
  logic                   out_vld_q, out_vld_d;
  res_t                   res_q, res_d;

  char_class_t       cls;
  mac_t              mac;
  logic              bad, live, subj, take, digit_ok, res_vld;
  logic [RadixW-1:0] subj_rad, b_raw, b;
  logic [ExtW-1:0]   pos_ext;
  res_t              fin;

  ttu_decode u_decode (
    .char_i (char_i),
    .cls_o  (cls)
  );

  ttu_mac u_mac (
    .acc_i   (acc_w),
    .radix_i (b),
    .digit_i (cls.dval),
    .mac_o   (mac)
  );

  // Working state: a start beat reloads everything, other beats of a live string advance the position
  always_comb begin
    phase_w = phase_q;
    ds_w    = ds_q;
    neg_w   = neg_q;
    acc_w   = acc_q;
    erad_w  = erad_q;
    pos_w   = pos_q;
    px_w    = px_q;
    bad     = 1'b0;
    live    = 1'b0;
    if (start_i) begin
      bad     = (radix_i == RadixOne) || (radix_i > RadixMax);
      live    = !bad;
      pos_w   = '0;
      neg_w   = 1'b0;
      acc_w   = '0;
      ds_w    = DS_NONE;
      erad_w  = bad ? RadixAuto : radix_i;
      px_w    = !bad && ((radix_i == RadixAuto) || (radix_i == RadixHex));
      phase_w = bad ? PH_IDLE : PH_LEAD;
    end else if (phase_q != PH_IDLE) begin
      live  = 1'b1;
      pos_w = (&pos_q) ? pos_q : pos_q + OFFSET_BITS'(1);
    end
    subj_rad = (erad_w == RadixAuto) ? RadixDec : erad_w;
    b_raw    = ((phase_w == PH_LEAD) || (phase_w == PH_SIGNED)) ? subj_rad : erad_w;
    b        = ((b_raw < 6'd2) || (b_raw > RadixMax)) ? RadixDec : b_raw;
    digit_ok = cls.is_digit && (cls.dval < b);
  end

  // Result of ending the conversion on the current beat
  always_comb begin
    pos_ext = ExtW'(pos_w);
    fin.value      = '0;
    fin.status     = ST_NODIG;
    fin.end_offset = '0;
    if (ds_w == DS_SOME) begin
      fin.value  = neg_w ? (ValueW'(0) - acc_w) : acc_w;
      fin.status = ST_OK;
    end else if (ds_w == DS_OVER) begin
      fin.value  = '1;
      fin.status = ST_RANGE;
    end
    if (ds_w != DS_NONE) begin
      fin.end_offset = (pos_ext > ExtW'(16'hffff)) ? 16'hffff : pos_ext[OffsetW-1:0];
    end
  end

  always_comb begin
    phase_d = phase_w;
    ds_d    = ds_w;
    neg_d   = neg_w;
    acc_d   = acc_w;
    erad_d  = erad_w;
    pos_d   = pos_w;
    px_d    = px_w;
    subj    = 1'b0;
    take    = 1'b0;
    res_vld = 1'b0;
    res_d   = fin;
    if (bad) begin
      res_vld          = 1'b1;
      res_d.value      = '0;
      res_d.end_offset = '0;
      res_d.status     = ST_RADIX;
    end else if (live) begin
      unique case (phase_w)
        PH_LEAD: begin
          if (cls.is_space) begin
            phase_d = PH_LEAD;
          end else if (cls.is_minus) begin
            neg_d   = 1'b1;
            phase_d = PH_SIGNED;
          end else if (cls.is_plus) begin
            phase_d = PH_SIGNED;
          end else begin
            subj = 1'b1;
          end
        end
        PH_SIGNED: subj = 1'b1;
        PH_ZERO: begin
          if (cls.is_x) begin
            erad_d  = RadixHex;
            acc_d   = '0;
            ds_d    = DS_NONE;
            phase_d = PH_HEXPFX;
          end else begin
            take = 1'b1;
          end
        end
        PH_HEXPFX, PH_DIGITS: take = 1'b1;
        default: phase_d = PH_IDLE;
      endcase
      if (subj) begin
        if (px_w && cls.is_zero) begin
          // leading zero: octal in auto mode, or the start of a hex prefix
          erad_d  = (erad_w == RadixAuto) ? RadixOct : RadixHex;
          acc_d   = '0;
          ds_d    = DS_SOME;
          phase_d = PH_ZERO;
        end else begin
          erad_d = subj_rad;
          take   = 1'b1;
        end
      end
      if (take) begin
        phase_d = PH_DIGITS;
        if (!digit_ok) begin
          res_vld = 1'b1;
          phase_d = PH_IDLE;
        end else if (ds_w == DS_OVER) begin
          ds_d = DS_OVER;
        end else if (mac.ovf) begin
          ds_d  = DS_OVER;
          acc_d = '1;
        end else begin
          ds_d  = DS_SOME;
          acc_d = mac.sum;
        end
      end
    end
    if (step_en_i) begin
      out_vld_d = res_vld;
    end else begin
      out_vld_d = out_vld_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      ds_q      <= DS_NONE;
      neg_q     <= 1'b0;
      acc_q     <= '0;
      erad_q    <= '0;
      pos_q     <= '0;
      px_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (step_en_i) begin
        phase_q <= phase_d;
        ds_q    <= ds_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        erad_q  <= erad_d;
        pos_q   <= pos_d;
        px_q    <= px_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en_i && res_vld) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

  `ASSERT_AT(a_bad_radix_answers, clk_i, rst_ni,
             (step_en_i && start_i && bad) |=> (out_vld_q && (res_q.status == ST_RADIX)))
  `ASSERT_AT(a_result_goes_idle, clk_i, rst_ni,
             (step_en_i && res_vld) |=> (phase_q == PH_IDLE))
  `ASSERT_NEVER(a_over_saturates, clk_i, rst_ni, (ds_q == DS_OVER) && (acc_q != '1))
  `ASSERT_AT(a_nodig_is_empty, clk_i, rst_ni,
             (out_vld_q && (res_q.status == ST_NODIG)) |->
             ((res_q.value == '0) && (res_q.end_offset == '0)))

endmodule
